### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands; the user module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/nhlt_pkg.sv
// ----------------------------------------------------------------------------
// nhlt_pkg
// Types and constants of the node heartbeat liveness table.
// ----------------------------------------------------------------------------
package nhlt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  localparam int ID_W        = 16;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 5;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_ID   = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0] TIMEOUT_RESET  = TIME_W'(1000);
  localparam logic [ID_W-1:0]   EMPTY_ID_RESET = ID_W'(65535);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_HB     = 2'd1,
    KIND_TMO    = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   sat_id;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic               any_offline;
    logic [ID_W-1:0]    first_offline_id;
    logic               found;
    logic               found_online;
    logic [TIME_W-1:0]  found_last_seen;
    logic               newly_added;
    logic               table_full;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              online;
    logic [TIME_W-1:0] last_seen;
  } slot_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       data;
  } ram_wr_t;

endpackage

### src/nhlt_slot_ram.sv
// ----------------------------------------------------------------------------
// nhlt_slot_ram
// Slot entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nhlt_slot_ram import nhlt_pkg::*; (
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_entry_t       rd_data
);

  slot_entry_t mem [TABLE_SLOTS];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/node_heartbeat_liveness_table.sv
// ----------------------------------------------------------------------------
// node_heartbeat_liveness_table
// Table of remote node IDs with online marks and last-seen times.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present in_word and raise start; the word is taken at the edge
//   where start is high and busy is low. busy stays high while the word runs.
//   Each word is add, heartbeat, timeout check or lookup.
//   Output: one result word per input word, on out_word with out_valid high
//   for exactly one cycle. The receiver cannot stall; it must take it then.
//   Timing: the sequencer walks all TABLE_SLOTS entries of the slot RAM once,
//   one read per cycle from the registered read port, writing back changed
//   entries as it goes; the done state then places a new entry. The result
//   is registered out of the done state, and a new word can be taken in the
//   cycle in which it shows.
//   Configuration: cfg_we writes timeout_ms (index 0) or empty_id (index 1);
//   other indexes are ignored. Write only while idle.
//   Reset: synchronous active-low rst_n empties the table through its valid
//   flops, restores timeout_ms 1000 and empty_id 65535.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module node_heartbeat_liveness_table import nhlt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 proc_vld_r, proc_vld_nxt;
  logic [SLOT_W-1:0]    proc_idx_r, proc_idx_nxt;
  in_word_t             req_r, req_nxt;
  logic [TIME_W-1:0]    timeout_r, timeout_nxt;
  logic [ID_W-1:0]      empty_id_r, empty_id_nxt;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic                 found_r, found_nxt;
  logic                 f_online_r, f_online_nxt;
  logic [TIME_W-1:0]    f_seen_r, f_seen_nxt;
  logic                 free_vld_r, free_vld_nxt;
  logic [SLOT_W-1:0]    free_idx_r, free_idx_nxt;
  logic                 any_off_r, any_off_nxt;
  logic [ID_W-1:0]      off_id_r, off_id_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  slot_entry_t          rd_data;
  ram_wr_t              ram_wr;
  logic                 issue;
  logic                 act, is_hb, is_tmo, wants_add;
  logic                 slot_vld, hit, expire, eff_online;
  logic                 add_now, full_now;
  logic [TIME_W-1:0]    age;
  logic [CNT_W:0]       total;

  nhlt_slot_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (issue),
    .rd_addr (cnt_r[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign is_tmo    = (req_r.kind == KIND_TMO);
  assign is_hb     = (req_r.kind == KIND_HB);
  assign act       = !is_tmo && (req_r.sat_id != empty_id_r);
  assign wants_add = act && (req_r.kind == KIND_ADD || is_hb);

  assign issue     = (state_r == ST_SCAN) && (cnt_r != CNT_W'(TABLE_SLOTS));
  assign slot_vld  = proc_vld_r && valid_r[proc_idx_r];
  assign age       = req_r.now_ms - rd_data.last_seen;
  assign hit       = slot_vld && act && (rd_data.id == req_r.sat_id);
  assign expire    = slot_vld && is_tmo && rd_data.online && (age > timeout_r);
  assign eff_online = (hit && is_hb) || (rd_data.online && !expire);

  assign add_now   = (state_r == ST_DONE) && wants_add && !found_r && free_vld_r;
  assign full_now  = (state_r == ST_DONE) && wants_add && !found_r && !free_vld_r;
  assign total     = (CNT_W + 1)'(occ_r) + (CNT_W + 1)'(add_now);

  always_comb begin
    ram_wr.we   = (hit && is_hb) || expire || add_now;
    ram_wr.addr = add_now ? free_idx_r : proc_idx_r;
    if (add_now) begin
      ram_wr.data = '{id: req_r.sat_id, online: 1'b1, last_seen: req_r.now_ms};
    end else if (hit && is_hb) begin
      ram_wr.data = '{id: rd_data.id, online: 1'b1, last_seen: req_r.now_ms};
    end else begin
      ram_wr.data = '{id: rd_data.id, online: 1'b0, last_seen: rd_data.last_seen};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    proc_vld_nxt  = issue;
    proc_idx_nxt  = cnt_r[SLOT_W-1:0];
    req_nxt       = req_r;
    timeout_nxt   = timeout_r;
    empty_id_nxt  = empty_id_r;
    valid_nxt     = valid_r;
    occ_nxt       = occ_r;
    found_nxt     = found_r;
    f_online_nxt  = f_online_r;
    f_seen_nxt    = f_seen_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    any_off_nxt   = any_off_r;
    off_id_nxt    = off_id_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT_MS: timeout_nxt  = cfg_wdata[TIME_W-1:0];
        CFG_EMPTY_ID:   empty_id_nxt = cfg_wdata[ID_W-1:0];
        default: ;
      endcase
    end

    if (proc_vld_r) begin
      if (slot_vld) begin
        occ_nxt = occ_r + CNT_W'(1);
        if (!eff_online && !any_off_r) begin
          any_off_nxt = 1'b1;
          off_id_nxt  = rd_data.id;
        end
      end else if (!free_vld_r) begin
        free_vld_nxt = 1'b1;
        free_idx_nxt = proc_idx_r;
      end
      if (hit) begin
        found_nxt    = 1'b1;
        f_online_nxt = eff_online;
        f_seen_nxt   = is_hb ? req_r.now_ms : rd_data.last_seen;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt    = ST_SCAN;
          cnt_nxt      = '0;
          req_nxt      = in_word;
          occ_nxt      = '0;
          found_nxt    = 1'b0;
          f_online_nxt = 1'b0;
          f_seen_nxt   = '0;
          free_vld_nxt = 1'b0;
          any_off_nxt  = 1'b0;
          off_id_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (add_now) begin
          valid_nxt[free_idx_r] = 1'b1;
        end
        out_word_nxt.entry_count      = COUNT_W'(total);
        out_word_nxt.any_offline      = any_off_r;
        out_word_nxt.first_offline_id = off_id_r;
        out_word_nxt.found            = found_r;
        out_word_nxt.found_online     = f_online_r;
        out_word_nxt.found_last_seen  = f_seen_r;
        out_word_nxt.newly_added      = add_now;
        out_word_nxt.table_full       = full_now;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      proc_vld_r  <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
      empty_id_r  <= EMPTY_ID_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      proc_vld_r  <= proc_vld_nxt;
      timeout_r   <= timeout_nxt;
      empty_id_r  <= empty_id_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    req_r      <= req_nxt;
    occ_r      <= occ_nxt;
    found_r    <= found_nxt;
    f_online_r <= f_online_nxt;
    f_seen_r   <= f_seen_nxt;
    free_vld_r <= free_vld_nxt;
    free_idx_r <= free_idx_nxt;
    any_off_r  <= any_off_nxt;
    off_id_r   <= off_id_nxt;
    out_word_r <= out_word_nxt;
  end

  `ASSERT_IMPL(a_strobe_after_done, out_valid_r, $past(state_r == ST_DONE), "strobe without finish")
  `ASSERT_NEXT(a_accept_starts_scan, start && !busy, state_r == ST_SCAN && cnt_r == '0, "scan not started")
  `ASSERT_IMPL(a_result_exclusive, out_valid_r, !(out_word_r.newly_added && (out_word_r.table_full || out_word_r.found)), "conflicting result flags")
  `ASSERT_IMPL(a_single_write_source, ram_wr.we, !(add_now && proc_vld_r), "write port conflict")

endmodule

### sim/nhlt_tb_pkg.sv
// ----------------------------------------------------------------------------
// nhlt_tb_pkg
// Scoreboard for the node heartbeat liveness table testbench. It keeps its
// own copy of the table and registers, works out the status word for every
// accepted command word and checks the block's words against them in order.
// ----------------------------------------------------------------------------
package nhlt_tb_pkg;
  import nhlt_pkg::*;

  class liveness_tracker;
    logic [TIME_W-1:0] timeout_ms;
    logic [ID_W-1:0]   empty_id;
    bit                slot_valid  [TABLE_SLOTS];
    logic [ID_W-1:0]   slot_id     [TABLE_SLOTS];
    bit                slot_online [TABLE_SLOTS];
    logic [TIME_W-1:0] slot_seen   [TABLE_SLOTS];
    out_word_t         status_due[$];
    int                errors;
    int                checked;
    int                added;
    int                refused;
    int                expired;

    function new();
      timeout_ms = TIMEOUT_RESET;
      empty_id   = EMPTY_ID_RESET;
      foreach (slot_valid[i]) begin
        slot_valid[i]  = 1'b0;
        slot_id[i]     = '0;
        slot_online[i] = 1'b0;
        slot_seen[i]   = '0;
      end
      errors  = 0;
      checked = 0;
      added   = 0;
      refused = 0;
      expired = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TIMEOUT_MS: timeout_ms = data[TIME_W-1:0];
        CFG_EMPTY_ID:   empty_id   = data[ID_W-1:0];
        default: ;
      endcase
    endfunction

    function out_word_t predict_status(in_word_t w);
      out_word_t         o;
      int                hit;
      int                free;
      int                cnt;
      logic [TIME_W-1:0] age;
      o    = '0;
      hit  = -1;
      free = -1;
      cnt  = 0;
      if (w.kind == KIND_TMO) begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          age = w.now_ms - slot_seen[i];
          if (slot_valid[i] && slot_online[i] && age > timeout_ms) begin
            slot_online[i] = 1'b0;
            expired++;
          end
        end
      end else if (w.sat_id != empty_id) begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (hit < 0 && slot_valid[i] && slot_id[i] == w.sat_id) hit = i;
          if (free < 0 && !slot_valid[i]) free = i;
        end
        if (hit >= 0) begin
          o.found = 1'b1;
          if (w.kind == KIND_HB) begin
            slot_online[hit] = 1'b1;
            slot_seen[hit]   = w.now_ms;
          end
          o.found_online    = slot_online[hit];
          o.found_last_seen = slot_seen[hit];
        end else if (w.kind != KIND_LOOKUP) begin
          if (free >= 0) begin
            slot_valid[free]  = 1'b1;
            slot_id[free]     = w.sat_id;
            slot_online[free] = 1'b1;
            slot_seen[free]   = w.now_ms;
            o.newly_added     = 1'b1;
            added++;
          end else begin
            o.table_full = 1'b1;
            refused++;
          end
        end
      end
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (slot_valid[i]) begin
          cnt++;
          if (!slot_online[i] && !o.any_offline) begin
            o.any_offline      = 1'b1;
            o.first_offline_id = slot_id[i];
          end
        end
      end
      o.entry_count = COUNT_W'(cnt);
      return o;
    endfunction

    function void note_word(in_word_t w);
      status_due.push_back(predict_status(w));
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch %0d: %s", errors, msg);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) flag($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    function void check_status(out_word_t got);
      out_word_t want;
      checked++;
      if (status_due.size() == 0) begin
        flag($sformatf("status word %h with nothing pending", got));
        return;
      end
      want = status_due.pop_front();
      check_field("entry_count", want.entry_count, got.entry_count);
      check_field("any_offline", want.any_offline, got.any_offline);
      check_field("first_offline_id", want.first_offline_id, got.first_offline_id);
      check_field("found", want.found, got.found);
      check_field("found_online", want.found_online, got.found_online);
      check_field("found_last_seen", want.found_last_seen, got.found_last_seen);
      check_field("newly_added", want.newly_added, got.newly_added);
      check_field("table_full", want.table_full, got.table_full);
    endfunction
  endclass

endpackage

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives add, heartbeat, timeout check and lookup words into the liveness
// table: a directed opening that covers reserved IDs, wrapping ages, known
// IDs and a full table, then random phases under extreme and random register
// settings with random sender gaps, each status word checked by a scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nhlt_pkg::*;
  import nhlt_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
  localparam int PHASE_WORDS = 450;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  liveness_tracker   sb;
  bit                start_up;
  int                words;
  logic [TIME_W-1:0] clock_ms;
  logic [ID_W-1:0]   pool [TABLE_SLOTS];

  always #5 clk = ~clk;

  node_heartbeat_liveness_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_status(out_word);
  end

  function automatic in_word_t word_of(kind_t k, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
    in_word_t w;
    w.kind   = k;
    w.sat_id = id;
    w.now_ms = t;
    return w;
  endfunction

  function automatic logic [TIME_W-1:0] tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) clock_ms = $urandom();
    else if (r < 40) clock_ms = clock_ms + $urandom_range(0, 100);
    else clock_ms = clock_ms + $urandom_range(0, 1500);
    return clock_ms;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    r = $urandom_range(0, 99);
    w.kind = (r < 15) ? KIND_ADD : (r < 55) ? KIND_HB : (r < 75) ? KIND_TMO : KIND_LOOKUP;
    r = $urandom_range(0, 99);
    if (r < 70) w.sat_id = pool[$urandom_range(0, TABLE_SLOTS - 1)];
    else if (r < 80) w.sat_id = sb.empty_id;
    else w.sat_id = ID_W'($urandom());
    w.now_ms = tick();
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    start    <= 1'b1;
    in_word  <= w;
    start_up = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_word(w);
    words++;
  endtask

  task automatic lower_start();
    if (start_up) begin
      start    <= 1'b0;
      start_up = 1'b0;
    end
  endtask

  task automatic pace(bit quiet);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      lower_start();
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  endtask

  task automatic drain();
    lower_start();
    while (sb.status_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // upper bits of the empty_id write and the spare index carry junk
  task automatic set_regs(logic [TIME_W-1:0] tmo, logic [ID_W-1:0] eid,
                          logic [CFG_IDX_W-1:0] spare);
    cfg_step(CFG_TIMEOUT_MS, tmo);
    cfg_step(CFG_EMPTY_ID, {16'($urandom()), eid});
    cfg_step(spare, $urandom());
    cfg_we <= 1'b0;
  endtask

  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    sb       = new();
    start_up = 1'b0;
    words    = 0;
    clock_ms = '0;
    pool[0]  = 16'h0000;
    pool[1]  = 16'hFFFE;
    for (int i = 2; i < TABLE_SLOTS; i++) pool[i] = ID_W'(i * 4099);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening under reset register values
    send_word(word_of(KIND_LOOKUP, 16'h1234, 32'd0));
    pace(0);
    send_word(word_of(KIND_ADD, 16'h0000, 32'd0));
    send_word(word_of(KIND_ADD, 16'h0000, 32'd5));
    pace(0);
    send_word(word_of(KIND_ADD, 16'hFFFF, 32'd7));
    send_word(word_of(KIND_HB, 16'hFFFE, 32'hFFFF_FFFF));
    // age wraps to 1001 for the second entry only
    send_word(word_of(KIND_TMO, 16'h5555, 32'd1000));
    send_word(word_of(KIND_LOOKUP, 16'hFFFE, 32'd1000));
    pace(0);
    send_word(word_of(KIND_HB, 16'hFFFE, 32'd2000));
    send_word(word_of(KIND_TMO, 16'hFFFF, 32'd3001));
    send_word(word_of(KIND_LOOKUP, 16'hFFFF, 32'd3001));
    for (int i = 2; i < TABLE_SLOTS; i++) begin
      send_word(word_of((i % 2) ? KIND_ADD : KIND_HB, pool[i], 32'(3001 + i)));
      pace(0);
    end
    send_word(word_of(KIND_ADD, 16'h1234, 32'd3100));
    send_word(word_of(KIND_HB, 16'h4321, 32'd3200));
    drain();

    clock_ms = 32'd3200;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_regs('0, '0, CFG_SPARE_LO);
        1: set_regs('1, '1, CFG_SPARE_HI);
        2: set_regs(TIME_W'($urandom_range(1, 3000)), pool[$urandom_range(0, TABLE_SLOTS - 1)],
                    CFG_SPARE_LO);
        default: set_regs(TIMEOUT_RESET, ID_W'($urandom()), CFG_SPARE_HI);
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
        // phase 1 runs back to back
        pace(ph == 1);
        if (ph != 1 && $urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.status_due.size() != 0)
      sb.flag($sformatf("%0d status words never arrived", sb.status_due.size()));

    $display("summary: %0d command words, %0d status words checked under five register settings",
             words, sb.checked);
    $display("summary: %0d entries added, %0d refused on a full table, %0d timed out",
             sb.added, sb.refused, sb.expired);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
